FILE: rtl/core/array_list_engine_macros.svh
// Assertion helpers for the core sequencer.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ALE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Trigger in one cycle implies the consequence in the next.
`define ALE_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/ale_pkg.sv
package ale_pkg;

	localparam int CAPACITY = 128;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 8;
	localparam int FIDX_W   = 7;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// operation codes
	localparam logic [2:0] K_INSERT  = 3'd0;
	localparam logic [2:0] K_DELETE  = 3'd1;
	localparam logic [2:0] K_REPLACE = 3'd2;
	localparam logic [2:0] K_READ    = 3'd3;
	localparam logic [2:0] K_FIND    = 3'd4;
	localparam logic [2:0] K_CLEAR   = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic [2:0]               kind;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] read_value;
		logic [FIDX_W-1:0]        found_index;
		logic                     found;
		logic [POS_W-1:0]         count;
		logic                     empty_flag;
		logic                     full_flag;
	} out_word_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

endpackage

FILE: rtl/core/ale_chan_if.sv
interface ale_in_if;
	import ale_pkg::*;
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ale_out_if;
	import ale_pkg::*;
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/array_list_engine.sv
// Channel | Dir | Word                           | Handshake
// cmd     | in  | kind, position, value          | valid/ready, taken when both high
// rsp     | out | status, read_value, found_index,| valid/ready, taken when both high
//         |     | found, count, empty/full flags |
//
// One word in the sequencer at a time. Replace, clear, append, tail delete and errors
//   finish without a walk; read waits for the registered RAM read; other deletes shift
//   entries p+1..n-1 down, other inserts shift p..n-1 up; find scans from 0 to a match or the end.
// The walks are bound by the single-port-read entry RAM, one entry per cycle.
// Reset clears count and control; entry RAM contents are not cleared.
// A done word waits in the rsp register; cmd stalls while a second one waits behind it.
module array_list_engine (
	input logic        clk,
	input logic        arst_n,
	ale_in_if.sink     cmd,
	ale_out_if.source  rsp
);
	import ale_pkg::*;

	ram_req_t          ram_req;
	logic [DATA_W-1:0] ram_rdata;
	logic              slot_free;
	logic              res_push;
	out_word_t         res_word;
	logic              rsp_vld_q;
	out_word_t         rsp_word_q;

	// entry store: one write and one read port, registered read
	ale_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// operation sequencer: shift walks, search, count
	ale_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_data  (cmd.data),
		.cmd_ready (cmd.ready),
		.slot_free (slot_free),
		.res_push  (res_push),
		.res_word  (res_word),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// output register: slot frees when empty or drained this cycle
	assign slot_free = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_push) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rsp_word_q <= res_word;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_word_q;

endmodule

FILE: rtl/core/ale_ram.sv
module ale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/core/ale_seq.sv
`include "array_list_engine_macros.svh"

module ale_seq (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  ale_pkg::in_word_t        cmd_data,
	output logic                     cmd_ready,
	input  logic                     slot_free,
	output logic                     res_push,
	output ale_pkg::out_word_t       res_word,
	output ale_pkg::ram_req_t        ram_req,
	input  logic [ale_pkg::DATA_W-1:0] ram_rdata
);
	import ale_pkg::*;

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_IDLE     = 4'd0;
	localparam logic [ST_W-1:0] S_UP       = 4'd1;
	localparam logic [ST_W-1:0] S_UP_DRAIN = 4'd2;
	localparam logic [ST_W-1:0] S_UP_FILL  = 4'd3;
	localparam logic [ST_W-1:0] S_DN       = 4'd4;
	localparam logic [ST_W-1:0] S_DN_DRAIN = 4'd5;
	localparam logic [ST_W-1:0] S_FIND     = 4'd6;
	localparam logic [ST_W-1:0] S_RD       = 4'd7;
	localparam logic [ST_W-1:0] S_RESULT   = 4'd8;

	logic [ST_W-1:0]   state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [CNT_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [IDX_W-1:0]  rd_addr_s1;
	logic              rd_vld_s1;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] rdval_q;
	logic [FIDX_W-1:0] fidx_q;
	logic              found_q;

	logic              accept;
	logic [CMP_W-1:0]  cmd_pos_c;
	logic [CMP_W-1:0]  cnt_c;
	logic              pos_lt;
	logic              ins_ok;
	logic [IDX_W-1:0]  cmd_idx;
	logic              find_issue;
	logic [IDX_W-1:0]  last_idx;

	assign cmd_ready  = (state_q == S_IDLE);
	assign accept     = cmd_valid && cmd_ready;
	assign cmd_pos_c  = CMP_W'(cmd_data.position);
	assign cnt_c      = CMP_W'(cnt_q);
	assign pos_lt     = cmd_pos_c < cnt_c;
	assign ins_ok     = (cnt_q != CNT_W'(CAPACITY)) && (cmd_pos_c <= cnt_c);
	assign cmd_idx    = IDX_W'(cmd_pos_c);
	assign find_issue = ptr_q < cnt_q;
	assign last_idx   = IDX_W'(cnt_q - 1'b1);

	// memory port control
	always_comb begin
		ram_req = '0;
		ram_req.wdata = cmd_data.value;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (cmd_data.kind)
						K_INSERT: ram_req.we = ins_ok && (cmd_pos_c == cnt_c);
						K_REPLACE: ram_req.we = pos_lt;
						K_READ: ram_req.re = pos_lt;
						default: ;
					endcase
				end
				ram_req.waddr = cmd_idx;
				ram_req.raddr = cmd_idx;
			end
			S_UP: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = ptr_q[IDX_W-1:0];
				ram_req.we    = rd_vld_s1;
				ram_req.waddr = rd_addr_s1 + 1'b1;
				ram_req.wdata = ram_rdata;
			end
			S_UP_DRAIN: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = rd_addr_s1 + 1'b1;
				ram_req.wdata = ram_rdata;
			end
			S_UP_FILL: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q[IDX_W-1:0];
				ram_req.wdata = val_q;
			end
			S_DN: begin
				ram_req.re    = 1'b1;
				ram_req.raddr = ptr_q[IDX_W-1:0];
				ram_req.we    = rd_vld_s1;
				ram_req.waddr = rd_addr_s1 - 1'b1;
				ram_req.wdata = ram_rdata;
			end
			S_DN_DRAIN: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = rd_addr_s1 - 1'b1;
				ram_req.wdata = ram_rdata;
			end
			S_FIND: begin
				ram_req.re    = find_issue;
				ram_req.raddr = ptr_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			ptr_q      <= '0;
			pos_q      <= '0;
			val_q      <= '0;
			rd_addr_s1 <= '0;
			rd_vld_s1  <= 1'b0;
			status_q   <= ST_OK;
			rdval_q    <= '0;
			fidx_q     <= '0;
			found_q    <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						pos_q    <= CNT_W'(cmd_pos_c);
						val_q    <= cmd_data.value;
						status_q <= ST_OK;
						rdval_q  <= '0;
						fidx_q   <= '0;
						found_q  <= 1'b0;
						state_q  <= S_RESULT;
						unique case (cmd_data.kind)
							K_INSERT: begin
								if (!ins_ok) begin
									status_q <= ST_FULL;
								end else if (cmd_pos_c == cnt_c) begin
									cnt_q <= cnt_q + 1'b1;
								end else begin
									ptr_q   <= cnt_q - 1'b1;
									state_q <= S_UP;
								end
							end
							K_DELETE: begin
								if (!pos_lt) begin
									status_q <= ST_EMPTY;
								end else if (cmd_pos_c + 1'b1 == cnt_c) begin
									cnt_q <= cnt_q - 1'b1;
								end else begin
									ptr_q   <= CNT_W'(cmd_pos_c + 1'b1);
									state_q <= S_DN;
								end
							end
							K_REPLACE: begin
								if (!pos_lt) begin
									status_q <= ST_EMPTY;
								end
							end
							K_READ: begin
								if (pos_lt) begin
									state_q <= S_RD;
								end else begin
									status_q <= ST_EMPTY;
								end
							end
							K_FIND: begin
								if (cnt_q == '0) begin
									status_q <= ST_MISS;
								end else begin
									ptr_q   <= '0;
									state_q <= S_FIND;
								end
							end
							K_CLEAR: cnt_q <= '0;
							default: ;
						endcase
					end
				end
				S_UP: begin
					rd_vld_s1  <= 1'b1;
					rd_addr_s1 <= ptr_q[IDX_W-1:0];
					if (ptr_q == pos_q) begin
						state_q <= S_UP_DRAIN;
					end else begin
						ptr_q <= ptr_q - 1'b1;
					end
				end
				S_UP_DRAIN: state_q <= S_UP_FILL;
				S_UP_FILL: begin
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_RESULT;
				end
				S_DN: begin
					rd_vld_s1  <= 1'b1;
					rd_addr_s1 <= ptr_q[IDX_W-1:0];
					if (ptr_q == cnt_q - 1'b1) begin
						state_q <= S_DN_DRAIN;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_DN_DRAIN: begin
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_RESULT;
				end
				S_FIND: begin
					if (find_issue) begin
						rd_vld_s1  <= 1'b1;
						rd_addr_s1 <= ptr_q[IDX_W-1:0];
						ptr_q      <= ptr_q + 1'b1;
					end
					if (rd_vld_s1 && (ram_rdata == val_q)) begin
						found_q  <= 1'b1;
						fidx_q   <= FIDX_W'(rd_addr_s1);
						state_q  <= S_RESULT;
					end else if (rd_vld_s1 && (rd_addr_s1 == last_idx)) begin
						status_q <= ST_MISS;
						state_q  <= S_RESULT;
					end
				end
				S_RD: begin
					rdval_q <= ram_rdata;
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_push = (state_q == S_RESULT) && slot_free;

	always_comb begin
		res_word.status      = status_q;
		res_word.read_value  = rdval_q;
		res_word.found_index = fidx_q;
		res_word.found       = found_q;
		res_word.count       = POS_W'(cnt_q);
		res_word.empty_flag  = (cnt_q == '0);
		res_word.full_flag   = (cnt_q == CNT_W'(CAPACITY));
	end

	`ALE_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`ALE_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE, "accept left sequencer idle")
	`ALE_ASSERT_ALWAYS(a_rw_clash, clk, arst_n, !(ram_req.we && ram_req.re && (ram_req.waddr == ram_req.raddr)), "read and write hit one entry")
	`ALE_ASSERT_NEXT(a_push_idle, clk, arst_n, res_push, state_q == S_IDLE, "sequencer stuck after result")

endmodule

FILE: sim/ale_list_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the list and checks each response word.
module ale_list_checker (
	input  logic clk,
	input  logic arst_n,
	ale_in_if    cmd,
	ale_out_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   peak_count
);
	import ale_pkg::*;

	logic [DATA_W-1:0] store [CAPACITY];
	int                n_entries = 0;
	out_word_t         predicted_rsp [$];
	int                n_fail = 0;
	int                n_pending = 0;
	int                n_checked = 0;
	int                n_peak = 0;
	out_word_t         want;

	assign fail_count = n_fail;
	assign pending    = n_pending;
	assign checked    = n_checked;
	assign peak_count = n_peak;

	// apply one command word to the shadow list, return the response it should give
	function automatic out_word_t list_apply(in_word_t w);
		out_word_t r;
		int        p;
		int        i;
		r = '0;
		r.status = ST_OK;
		p = int'(w.position);
		case (w.kind)
			K_INSERT: begin
				if (n_entries < CAPACITY && p <= n_entries) begin
					for (i = n_entries; i > p; i--)
						store[i] = store[i-1];
					store[p] = w.value;
					n_entries++;
				end else
					r.status = ST_FULL;
			end
			K_DELETE: begin
				if (p < n_entries) begin
					for (i = p + 1; i < n_entries; i++)
						store[i-1] = store[i];
					n_entries--;
				end else
					r.status = ST_EMPTY;
			end
			K_REPLACE: begin
				if (p < n_entries)
					store[p] = w.value;
				else
					r.status = ST_EMPTY;
			end
			K_READ: begin
				if (p < n_entries)
					r.read_value = store[p];
				else
					r.status = ST_EMPTY;
			end
			K_FIND: begin
				r.status = ST_MISS;
				for (i = 0; i < n_entries && !r.found; i++) begin
					if (store[i] == w.value) begin
						r.status      = ST_OK;
						r.found       = 1'b1;
						r.found_index = i[FIDX_W-1:0];
					end
				end
			end
			K_CLEAR: n_entries = 0;
			default: ;
		endcase
		r.count      = n_entries[POS_W-1:0];
		r.empty_flag = (n_entries == 0);
		r.full_flag  = (n_entries == CAPACITY);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			n_fail++;
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_entries = 0;
			predicted_rsp.delete();
			n_pending = 0;
		end else begin
			// response first: it can only belong to an earlier command
			if (rsp.valid && rsp.ready) begin
				if (predicted_rsp.size() == 0) begin
					n_fail++;
					$display("%0t ns: response word with none outstanding, expected nothing, got %h",
						$time, rsp.data);
				end else begin
					want = predicted_rsp.pop_front();
					check_field("status", 32'(want.status), 32'(rsp.data.status));
					check_field("read_value", want.read_value, rsp.data.read_value);
					check_field("found_index", 32'(want.found_index), 32'(rsp.data.found_index));
					check_field("found", 32'(want.found), 32'(rsp.data.found));
					check_field("count", 32'(want.count), 32'(rsp.data.count));
					check_field("empty_flag", 32'(want.empty_flag), 32'(rsp.data.empty_flag));
					check_field("full_flag", 32'(want.full_flag), 32'(rsp.data.full_flag));
					n_checked++;
				end
			end
			if (cmd.valid && cmd.ready) begin
				predicted_rsp.push_back(list_apply(cmd.data));
				if (n_entries > n_peak)
					n_peak = n_entries;
			end
			n_pending = predicted_rsp.size();
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the list engine; all checking lives in the checker.
module tb;
	import ale_pkg::*;

	localparam int TOTAL_WORDS  = 450;
	localparam int QUIET_WORDS  = 60;      // tail of the run without idling
	localparam int CYCLE_LIMIT  = 600000;  // watchdog limit for the whole run
	localparam int DRAIN_CYCLES = 200;     // linger after the drain for stray responses
	localparam int HOLD_CYCLES  = 400;     // long response stall, backs up cmd

	// codes the block treats as no-ops
	localparam logic [2:0] K_SPARE0 = 3'd6;
	localparam logic [2:0] K_SPARE1 = 3'd7;

	// appended during the fill; unique so a find can hit the top slot
	localparam logic [31:0] FILL_TAG = 32'h5A5A_0000;

	logic clk;
	logic arst_n;

	ale_in_if  cmd ();
	ale_out_if rsp ();

	array_list_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	int n_fail;
	int n_pending;
	int n_checked;
	int n_peak;

	ale_list_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rsp        (rsp),
		.fail_count (n_fail),
		.pending    (n_pending),
		.checked    (n_checked),
		.peak_count (n_peak)
	);

	int          words_sent = 0;
	int          list_len   = 0;   // rough count, only to aim positions
	int          kind_hits [8];
	int          cycles     = 0;
	bit          quiet      = 1'b0;
	bit          hold_now   = 1'b0;
	bit          hold_taken = 1'b0;
	logic [31:0] value_pool [16];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL array_list_engine");
			$finish;
		end
	end

	// response side: random ready, one long hold when asked, steady at the end
	initial begin
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_now && !hold_taken) begin
				hold_taken = 1'b1;
				rsp.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (quiet) begin
				rsp.ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				rsp.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// offer one word, maybe after an idle burst, and hold it until taken
	task automatic put_word(logic [2:0] k, logic [POS_W-1:0] p, logic [31:0] v);
		in_word_t w;
		w.kind     = k;
		w.position = p;
		w.value    = v;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			cmd.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data  <= w;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		words_sent++;
		kind_hits[k]++;
		// track length so later positions land mostly in range
		case (k)
			K_INSERT: if (list_len < CAPACITY && int'(p) <= list_len) list_len++;
			K_DELETE: if (int'(p) < list_len) list_len--;
			K_CLEAR:  list_len = 0;
			default:  ;
		endcase
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 11);
		case (r)
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			4, 5:    return $urandom();
			default: return value_pool[$urandom_range(0, 15)];  // repeats give find hits
		endcase
	endfunction

	// bias: 0 mixed, 1 growing, 2 shrinking
	task automatic put_random(int bias);
		int          roll;
		int          r2;
		logic [2:0]  k;
		int          p;
		logic [31:0] v;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			// noise: any kind, any position
			put_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom());
		end else begin
			r2 = $urandom_range(0, 99);
			case (bias)
				1: k = (r2 < 65) ? K_INSERT : (r2 < 75) ? K_READ : (r2 < 85) ? K_FIND :
					(r2 < 93) ? K_REPLACE : K_DELETE;
				2: k = (r2 < 60) ? K_DELETE : (r2 < 72) ? K_READ : (r2 < 84) ? K_FIND :
					(r2 < 92) ? K_REPLACE : K_INSERT;
				default: k = (r2 < 2) ? K_CLEAR : 3'($urandom_range(0, 4));
			endcase
			if (k == K_INSERT)
				p = $urandom_range(0, list_len);
			else
				p = (list_len > 0) ? $urandom_range(0, list_len - 1) : 0;
			v = pick_value();
			put_word(k, 8'(p), v);
		end
	endtask

	task automatic run_directed();
		// empty list: every access fails
		put_word(K_READ,    8'd0,   32'h0000_0000);
		put_word(K_DELETE,  8'd0,   32'h0000_0000);
		put_word(K_REPLACE, 8'd0,   32'h1234_5678);
		put_word(K_FIND,    8'd0,   32'h0000_0000);
		put_word(K_INSERT,  8'd1,   32'h0000_0001);   // past count
		// build [min, -1, max, 0] through front, middle and tail inserts
		put_word(K_INSERT,  8'd0,   32'h7FFF_FFFF);
		put_word(K_INSERT,  8'd0,   32'h8000_0000);
		put_word(K_INSERT,  8'd2,   32'h0000_0000);
		put_word(K_INSERT,  8'd1,   32'hFFFF_FFFF);
		put_word(K_READ,    8'd0,   32'h0000_0000);
		put_word(K_READ,    8'd1,   32'h0000_0000);
		put_word(K_READ,    8'd4,   32'h0000_0000);   // pos == count
		put_word(K_READ,    8'd255, 32'h0000_0000);
		put_word(K_REPLACE, 8'd3,   32'h5555_5555);
		put_word(K_REPLACE, 8'd255, 32'hAAAA_AAAA);
		put_word(K_FIND,    8'd0,   32'hFFFF_FFFF);
		put_word(K_FIND,    8'd0,   32'hAAAA_AAAA);   // no match
		put_word(K_DELETE,  8'd255, 32'h0000_0000);
		put_word(K_DELETE,  8'd4,   32'h0000_0000);
		put_word(K_DELETE,  8'd0,   32'h0000_0000);
		put_word(K_SPARE0,  8'd17,  32'hDEAD_BEEF);   // no-op codes
		put_word(K_SPARE1,  8'd255, 32'hFFFF_FFFF);
		put_word(K_INSERT,  8'd128, 32'h0000_0002);
		put_word(K_CLEAR,   8'd0,   32'h0000_0000);
		put_word(K_READ,    8'd0,   32'h0000_0000);   // after clear
	endtask

	// append to capacity with the response side parked, then poke the full list
	task automatic fill_to_capacity();
		hold_now = 1'b1;
		while (list_len < CAPACITY)
			put_word(K_INSERT, 8'(list_len), FILL_TAG + 32'(list_len));
		put_word(K_INSERT,  8'd0,   32'h0BAD_0BAD);   // full
		put_word(K_INSERT,  8'd128, 32'h0BAD_0BAD);   // full and at end
		put_word(K_FIND,    8'd0,   FILL_TAG + 32'(CAPACITY - 1));   // hit in top slot
		put_word(K_FIND,    8'd0,   32'h0BAD_0BAD);   // full walk, miss
		put_word(K_READ,    8'd127, 32'h0000_0000);
		put_word(K_REPLACE, 8'd127, 32'h8000_0000);
		put_word(K_READ,    8'd127, 32'h0000_0000);
		put_word(K_DELETE,  8'd127, 32'h0000_0000);
		put_word(K_INSERT,  8'd127, 32'h7FFF_FFFF);
		put_word(K_DELETE,  8'd0,   32'h0000_0000);   // longest shift down
		put_word(K_INSERT,  8'd0,   32'hFFFF_FFFF);   // longest shift up
	endtask

	task automatic run_random();
		int i;
		int bias;
		int len;
		int fill_at;
		bit filled;
		for (i = 0; i < 16; i++)
			value_pool[i] = $urandom();
		fill_at = $urandom_range(90, 180);
		filled  = 1'b0;
		while (words_sent < TOTAL_WORDS) begin
			if (!filled && words_sent >= fill_at) begin
				fill_to_capacity();
				filled = 1'b1;
			end
			quiet = (words_sent >= TOTAL_WORDS - QUIET_WORDS);
			bias  = $urandom_range(0, 2);
			len   = $urandom_range(8, 30);
			repeat (len)
				put_random(bias);
		end
		quiet = 1'b1;
	endtask

	initial begin
		for (int j = 0; j < 8; j++)
			kind_hits[j] = 0;
		cmd.valid <= 1'b0;
		cmd.data  <= '0;
		arst_n    <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random();
		cmd.valid <= 1'b0;

		// drain, then linger long enough to catch any stray response
		while (n_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words: insert %0d, delete %0d, replace %0d, read %0d, find %0d, clear %0d, no-op %0d",
			words_sent, kind_hits[K_INSERT], kind_hits[K_DELETE], kind_hits[K_REPLACE],
			kind_hits[K_READ], kind_hits[K_FIND], kind_hits[K_CLEAR],
			kind_hits[K_SPARE0] + kind_hits[K_SPARE1]);
		$display("Checked %0d responses, list reached %0d entries, %0d mismatches",
			n_checked, n_peak, n_fail);
		if (n_fail == 0)
			$display("PASS array_list_engine");
		else
			$display("FAIL array_list_engine");
		$finish;
	end

endmodule
